[rtl/mic_e_position_decoder_unit_macros.svh]
// ---------------------------------------------------------------------------
// Mic-E position decoder assertion macros
// Shared property forms for the checker
// ---------------------------------------------------------------------------
`ifndef MIC_E_POSITION_DECODER_UNIT_MACROS_SVH
`define MIC_E_POSITION_DECODER_UNIT_MACROS_SVH

// same-cycle implication, masked during reset
`define MICEPD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, masked during reset
`define MICEPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// next-cycle implication, checked through reset
`define MICEPD_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/micepd_pkg.sv]
// ---------------------------------------------------------------------------
// Mic-E position decoder package
// Shared types and constants of the decoder
// ---------------------------------------------------------------------------
package micepd_pkg;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    // classified report between front and back
    typedef struct packed {
        logic        ok;
        logic [6:0]  lat_degrees;
        logic [13:0] lat_min_x100;
        logic        lat_south;
        logic [7:0]  lon_degrees;
        logic        lon_west;
        logic [3:0]  msg_code;
        logic [15:0] symbol_pair;
        logic [9:0]  course_deg;
        logic [10:0] speed_kn;
        logic [14:0] lm100;
        logic [2:0]  amb;
    } t_mid;

endpackage

[rtl/micepd_ifs.sv]
// ---------------------------------------------------------------------------
// Mic-E position decoder channels
// Valid/ready channels for reports, classified items and results
// ---------------------------------------------------------------------------
interface micepd_in_if ();
    logic        valid;
    logic        ready;
    logic [47:0] dest_chars;
    logic [7:0]  dest_length;
    logic [7:0]  info_type;
    logic [15:0] info_len;
    logic [63:0] body_bytes;

    modport source (output valid, dest_chars, dest_length, info_type, info_len,
                    body_bytes, input ready);
    modport sink (input valid, dest_chars, dest_length, info_type, info_len,
                  body_bytes, output ready);
endinterface

interface micepd_mid_if import micepd_pkg::*; ();
    logic valid;
    logic ready;
    t_mid data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

interface micepd_out_if ();
    logic        valid;
    logic        ready;
    logic        valid_res;
    logic [6:0]  lat_degrees;
    logic [13:0] lat_min_x100;
    logic        lat_south;
    logic [7:0]  lon_degrees;
    logic [14:0] lon_min_x100;
    logic        lon_west;
    logic [11:0] speed_kph;
    logic [9:0]  course_deg;
    logic [3:0]  msg_code;
    logic [15:0] symbol_pair;

    modport source (output valid, valid_res, lat_degrees, lat_min_x100, lat_south,
                    lon_degrees, lon_min_x100, lon_west, speed_kph, course_deg,
                    msg_code, symbol_pair, input ready);
    modport sink (input valid, valid_res, lat_degrees, lat_min_x100, lat_south,
                  lon_degrees, lon_min_x100, lon_west, speed_kph, course_deg,
                  msg_code, symbol_pair, output ready);
endinterface

[rtl/mic_e_position_decoder_unit.sv]
// ---------------------------------------------------------------------------
// Mic-E position decoder unit
// Decodes one Mic-E position report per item into numeric position fields
// ---------------------------------------------------------------------------
// usage:
//   i_in carries one report per item: destination bytes and length, info type,
//   info length and info bytes 1..8. o_out carries one result item per report,
//   valid_res low with all fields zero when the report is rejected.
//   path: the front register loads at the accepting edge, then the item is
//   registered in the queue, back stage one and the result register in
//   turn, after which the result item can be taken.
//   throughput: one item per cycle sustained while o_out.ready is high; the
//   two multiplier stages of the back part are fully pipelined.
//   reset: synchronous, active low; empties the front register, the two-entry
//   queue and both back stages, no result is shown after reset.
//   stall: when o_out.ready is low the result holds; back stages, queue and
//   front register keep filling, i_in.ready drops only when all are full.
// ---------------------------------------------------------------------------
module mic_e_position_decoder_unit import micepd_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    micepd_in_if.sink    i_in,
    micepd_out_if.source o_out
);

    micepd_mid_if u_f2q ();
    micepd_mid_if u_q2b ();

    micepd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_mid   (u_f2q)
    );

    micepd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mid   (u_f2q),
        .o_mid   (u_q2b)
    );

    micepd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mid   (u_q2b),
        .o_out   (o_out)
    );

endmodule

[rtl/micepd_front.sv]
// ---------------------------------------------------------------------------
// Mic-E decoder front
// Accepts a report, checks it and decodes the destination and body bytes
// ---------------------------------------------------------------------------
module micepd_front import micepd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    micepd_in_if.sink  i_in,
    micepd_mid_if.source o_mid
);

    localparam logic [7:0] C_BACKTICK = 8'h60;
    localparam logic [7:0] C_APOS     = 8'h27;
    localparam logic [7:0] C_BLANK    = 8'h20;
    localparam logic [7:0] C_ZERO     = 8'h30;
    localparam logic [7:0] C_NINE     = 8'h39;
    localparam logic [7:0] C_UA       = 8'h41;
    localparam logic [7:0] C_UK       = 8'h4B;
    localparam logic [7:0] C_UL       = 8'h4C;
    localparam logic [7:0] C_UP       = 8'h50;
    localparam logic [7:0] C_UZ       = 8'h5A;
    localparam logic [7:0] C_BIAS     = 8'd28;

    logic        r_valid;
    t_mid        r_item;
    t_mid        n_item;

    logic [7:0]  dc [6];
    logic [7:0]  tc [6];
    logic [3:0]  dg [6];
    logic [7:0]  bb [8];
    logic [2:0]  amb;
    logic [2:0]  idx;
    logic        custom;
    logic signed [9:0]  lng;
    logic [7:0]  lmin;
    logic [7:0]  lfrac;
    logic [7:0]  s0;
    logic [7:0]  c0;
    logic [16:0] cq_prod;
    logic [4:0]  cq;
    logic [7:0]  rem8;
    logic signed [11:0] crs;
    logic [11:0] sp;

    always_comb begin
        for (int i = 0; i < 6; i++) begin
            dc[i] = i_in.dest_chars[47 - 8 * i -: 8];
            if (dc[i] == C_UK || dc[i] == C_UL || dc[i] == C_UZ) begin
                tc[i] = C_BLANK;
            end else if (dc[i] > C_UL) begin
                tc[i] = dc[i] - 8'd32;
            end else if (dc[i] > C_NINE) begin
                tc[i] = dc[i] - 8'd17;
            end else begin
                tc[i] = dc[i];
            end
            dg[i] = (tc[i] >= C_ZERO && tc[i] <= C_NINE) ? 4'(tc[i] - C_ZERO) : 4'd0;
        end
        for (int k = 0; k < 8; k++) begin
            bb[k] = i_in.body_bytes[63 - 8 * k -: 8];
        end

        // trailing blank digits
        if (tc[5] != C_BLANK)      amb = 3'd0;
        else if (tc[4] != C_BLANK) amb = 3'd1;
        else if (tc[3] != C_BLANK) amb = 3'd2;
        else if (tc[2] != C_BLANK) amb = 3'd3;
        else if (tc[1] != C_BLANK) amb = 3'd4;
        else if (tc[0] != C_BLANK) amb = 3'd5;
        else                       amb = 3'd6;

        if (amb >= 3'd4)      dg[2] = 4'd3;
        else if (amb == 3'd3) dg[3] = 4'd5;
        else if (amb == 3'd2) dg[4] = 4'd5;
        else if (amb == 3'd1) dg[5] = 4'd5;

        // message bits
        idx    = 3'd0;
        custom = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if ((dc[i] >= C_ZERO && dc[i] <= C_NINE) || dc[i] == C_UL) begin
                idx[2 - i] = 1'b0;
            end else if (dc[i] >= C_UP && dc[i] <= C_UZ) begin
                idx[2 - i] = 1'b1;
            end else if (dc[i] >= C_UA && dc[i] <= C_UK) begin
                idx[2 - i] = 1'b1;
                custom     = 1'b1;
            end else begin
                custom = 1'b1;
            end
        end

        // longitude degrees
        lng = $signed({2'b00, bb[0]}) - 10'sd28;
        if (dc[4] >= C_UP) lng = lng + 10'sd100;
        if (lng >= 10'sd180 && lng <= 10'sd189) lng = lng - 10'sd80;
        if (lng >= 10'sd190 && lng <= 10'sd199) lng = lng - 10'sd190;

        // longitude minutes
        lmin = (bb[1] >= C_BIAS) ? bb[1] - C_BIAS : 8'd0;
        if (lmin >= 8'd60) lmin = lmin - 8'd60;
        lfrac = (bb[2] >= C_BIAS) ? bb[2] - C_BIAS : 8'd0;
        if (lfrac > 8'd99) lfrac = 8'd99;

        // speed and course
        s0      = (bb[3] >= C_BIAS) ? bb[3] - C_BIAS : 8'd0;
        c0      = (bb[4] >= C_BIAS) ? bb[4] - C_BIAS : 8'd0;
        cq_prod = {9'd0, c0} * 17'd410;
        cq      = cq_prod[16:12];
        rem8    = c0 - {cq, 3'b000} - {2'b00, cq, 1'b0};
        crs     = $signed({1'b0, 11'({7'd0, rem8[3:0]} * 11'd100)})
                + $signed({4'd0, bb[5]}) - 12'sd28;
        if (crs >= 12'sd400) crs = crs - 12'sd400;
        if (crs < 12'sd0)    crs = 12'sd0;
        sp = 12'({4'd0, s0} * 12'd10) + {7'd0, cq};
        if (sp >= 12'd800) sp = sp - 12'd800;

        n_item.ok = (i_in.info_type == C_BACKTICK || i_in.info_type == C_APOS)
                  && i_in.info_len >= 16'd9 && i_in.dest_length == 8'd6;
        n_item.lat_degrees  = 7'({3'd0, dg[0]} * 7'd10) + {3'd0, dg[1]};
        n_item.lat_min_x100 = 14'({10'd0, dg[2]} * 14'd1000) + 14'({10'd0, dg[3]} * 14'd100)
                            + 14'({10'd0, dg[4]} * 14'd10) + {10'd0, dg[5]};
        n_item.lat_south    = (dc[3] <= C_UL);
        n_item.lon_degrees  = (lng < 10'sd0)   ? 8'd0 :
                              (lng > 10'sd179) ? 8'd179 : lng[7:0];
        n_item.lon_west     = (dc[5] >= C_UP);
        n_item.msg_code     = {custom, ~idx};
        n_item.symbol_pair  = {bb[6], bb[7]};
        n_item.course_deg   = crs[9:0];
        n_item.speed_kn     = sp[10:0];
        n_item.lm100        = 15'({7'd0, lmin} * 15'd100) + {7'd0, lfrac};
        n_item.amb          = amb;
    end

    assign i_in.ready  = !r_valid || o_mid.ready;
    assign o_mid.valid = r_valid;
    assign o_mid.data  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= n_item;
        end
    end

endmodule

[rtl/micepd_queue.sv]
// ---------------------------------------------------------------------------
// Mic-E decoder queue
// Short register queue between the front and the back
// ---------------------------------------------------------------------------
module micepd_queue import micepd_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    micepd_mid_if.sink   i_mid,
    micepd_mid_if.source o_mid
);

    t_mid              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;

    assign i_mid.ready = (r_count != QCNT_W'(QDEPTH));
    assign o_mid.valid = (r_count != '0);
    assign o_mid.data  = r_mem[r_rd_ptr];
    assign push        = i_mid.valid && i_mid.ready;
    assign pop         = o_mid.valid && o_mid.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_mid.data;
        end
    end

endmodule

[rtl/micepd_back.sv]
// ---------------------------------------------------------------------------
// Mic-E decoder back
// Ambiguity rounding and knot conversion in two stages, result register
// ---------------------------------------------------------------------------
module micepd_back import micepd_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    micepd_mid_if.sink   i_mid,
    micepd_out_if.source o_out
);

    // reciprocals exact over the value ranges in use
    localparam logic [15:0] M_DIV10    = 16'd52429;
    localparam logic [15:0] M_DIV100   = 16'd41944;
    localparam logic [15:0] M_DIV1000S = 16'd33555;
    localparam logic [22:0] M_DIV1000W = 23'd4294968;

    typedef struct packed {
        t_mid        base;
        logic [14:0] lq;
        logic [9:0]  ld;
        logic [21:0] sp_num;
    } t_b1;

    logic        r_b1_valid;
    t_b1         r_b1;
    t_b1         n_b1;
    logic        b1_ready;
    logic        r_o_valid;
    logic        o_ready;

    logic [14:0] half;
    logic [15:0] mul_k;
    logic [14:0] x;
    logic [31:0] lm_prod;

    logic [44:0] sp_prod;
    logic [24:0] lm_full;

    logic        r_valid_res;
    logic [6:0]  r_lat_degrees;
    logic [13:0] r_lat_min_x100;
    logic        r_lat_south;
    logic [7:0]  r_lon_degrees;
    logic [14:0] r_lon_min_x100;
    logic        r_lon_west;
    logic [11:0] r_speed_kph;
    logic [9:0]  r_course_deg;
    logic [3:0]  r_msg_code;
    logic [15:0] r_symbol_pair;

    // stage one: minutes quotient and knot product
    always_comb begin
        unique case (i_mid.data.amb)
            3'd1:    begin half = 15'd5;   mul_k = M_DIV10;    end
            3'd2:    begin half = 15'd50;  mul_k = M_DIV100;   end
            3'd3:    begin half = 15'd500; mul_k = M_DIV1000S; end
            default: begin half = 15'd0;   mul_k = 16'd0;      end
        endcase
        x       = i_mid.data.lm100 + half;
        lm_prod = {17'd0, x} * {16'd0, mul_k};

        n_b1.base = i_mid.data;
        unique case (i_mid.data.amb)
            3'd0:    begin n_b1.lq = i_mid.data.lm100;        n_b1.ld = 10'd1;    end
            3'd1:    begin n_b1.lq = 15'(lm_prod[31:19]);     n_b1.ld = 10'd10;   end
            3'd2:    begin n_b1.lq = 15'(lm_prod[31:22]);     n_b1.ld = 10'd100;  end
            3'd3:    begin n_b1.lq = 15'(lm_prod[31:25]);     n_b1.ld = 10'd1000; end
            default: begin n_b1.lq = 15'd3000;                n_b1.ld = 10'd1;    end
        endcase
        n_b1.sp_num = 22'({11'd0, i_mid.data.speed_kn} * 22'd1852) + 22'd500;
    end

    // stage two: scale back minutes, divide knot product by 1000
    assign lm_full = {10'd0, r_b1.lq} * {15'd0, r_b1.ld};
    assign sp_prod = {23'd0, r_b1.sp_num} * {22'd0, M_DIV1000W};

    assign o_ready     = !r_o_valid || o_out.ready;
    assign b1_ready    = !r_b1_valid || o_ready;
    assign i_mid.ready = b1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (b1_ready) begin
                r_b1_valid <= i_mid.valid;
            end
            if (o_ready) begin
                r_o_valid <= r_b1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_mid.valid && b1_ready) begin
            r_b1 <= n_b1;
        end
        if (r_b1_valid && o_ready) begin
            if (r_b1.base.ok) begin
                r_valid_res    <= 1'b1;
                r_lat_degrees  <= r_b1.base.lat_degrees;
                r_lat_min_x100 <= r_b1.base.lat_min_x100;
                r_lat_south    <= r_b1.base.lat_south;
                r_lon_degrees  <= r_b1.base.lon_degrees;
                r_lon_min_x100 <= lm_full[14:0];
                r_lon_west     <= r_b1.base.lon_west;
                r_speed_kph    <= sp_prod[43:32];
                r_course_deg   <= r_b1.base.course_deg;
                r_msg_code     <= r_b1.base.msg_code;
                r_symbol_pair  <= r_b1.base.symbol_pair;
            end else begin
                r_valid_res    <= 1'b0;
                r_lat_degrees  <= '0;
                r_lat_min_x100 <= '0;
                r_lat_south    <= 1'b0;
                r_lon_degrees  <= '0;
                r_lon_min_x100 <= '0;
                r_lon_west     <= 1'b0;
                r_speed_kph    <= '0;
                r_course_deg   <= '0;
                r_msg_code     <= '0;
                r_symbol_pair  <= '0;
            end
        end
    end

    assign o_out.valid        = r_o_valid;
    assign o_out.valid_res    = r_valid_res;
    assign o_out.lat_degrees  = r_lat_degrees;
    assign o_out.lat_min_x100 = r_lat_min_x100;
    assign o_out.lat_south    = r_lat_south;
    assign o_out.lon_degrees  = r_lon_degrees;
    assign o_out.lon_min_x100 = r_lon_min_x100;
    assign o_out.lon_west     = r_lon_west;
    assign o_out.speed_kph    = r_speed_kph;
    assign o_out.course_deg   = r_course_deg;
    assign o_out.msg_code     = r_msg_code;
    assign o_out.symbol_pair  = r_symbol_pair;

endmodule

[rtl/micepd_checker.sv]
// ---------------------------------------------------------------------------
// Mic-E decoder checker
// Port-level properties of the decoder result channel
// ---------------------------------------------------------------------------
`include "mic_e_position_decoder_unit_macros.svh"

module micepd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_valid_res,
    input logic [6:0]  i_lat_degrees,
    input logic [13:0] i_lat_min_x100,
    input logic        i_lat_south,
    input logic [7:0]  i_lon_degrees,
    input logic [14:0] i_lon_min_x100,
    input logic        i_lon_west,
    input logic [11:0] i_speed_kph,
    input logic [9:0]  i_course_deg,
    input logic [3:0]  i_msg_code,
    input logic [15:0] i_symbol_pair
);

    logic [88:0] res_bits;
    logic        stalled;
    logic        rejected;
    logic        decoded;
    logic        ranges_ok;

    assign res_bits = {i_valid_res, i_lat_degrees, i_lat_min_x100, i_lat_south,
                       i_lon_degrees, i_lon_min_x100, i_lon_west, i_speed_kph,
                       i_course_deg, i_msg_code, i_symbol_pair};

    assign stalled   = i_out_valid && !i_out_ready;
    assign rejected  = i_out_valid && !i_valid_res;
    assign decoded   = i_out_valid && i_valid_res;
    assign ranges_ok = i_lat_degrees <= 7'd99 && i_lat_min_x100 <= 14'd9999
                     && i_lon_degrees <= 8'd179 && i_lon_min_x100 <= 15'd17000
                     && i_course_deg <= 10'd727;

    `MICEPD_ASSERT_RST(a_reset_empty, !i_rst_n, !i_out_valid, "result shown after reset")

    `MICEPD_ASSERT_NEXT(a_stall_hold, stalled, i_out_valid && $stable(res_bits), "stalled result changed")

    `MICEPD_ASSERT_SAME(a_reject_zero, rejected, res_bits == 89'd0, "rejected report has nonzero fields")

    `MICEPD_ASSERT_SAME(a_ranges, decoded, ranges_ok, "decoded field out of range")

endmodule

bind mic_e_position_decoder_unit micepd_checker u_micepd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_valid_res    (o_out.valid_res),
    .i_lat_degrees  (o_out.lat_degrees),
    .i_lat_min_x100 (o_out.lat_min_x100),
    .i_lat_south    (o_out.lat_south),
    .i_lon_degrees  (o_out.lon_degrees),
    .i_lon_min_x100 (o_out.lon_min_x100),
    .i_lon_west     (o_out.lon_west),
    .i_speed_kph    (o_out.speed_kph),
    .i_course_deg   (o_out.course_deg),
    .i_msg_code     (o_out.msg_code),
    .i_symbol_pair  (o_out.symbol_pair)
);
